// ===== rtl/sem_pkg.sv =====
// Shared types, constants and helpers for the Sobel edge magnitude block.
// Used by the front, queue, back and top-level modules; no dependencies.
package sem_pkg;

    localparam int PIX_W      = 16;
    localparam int COORD_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 10;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXVAL = 2'd2;

    // Squared sum of two 19-bit signed gradients fits in 38 bits.
    localparam int GRAD_W = 19;
    localparam int SQ_W   = 38;
    localparam int ROOT_W = SQ_W / 2;
    localparam int SQ_CNT_W = 5;

    // One window result request handed from front to back.
    typedef struct packed {
        logic [PIX_W-1:0]   w0, w1, w2, w3, w4, w5, w6, w7, w8;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
        logic               fend;
    } job_t;

endpackage

// ===== rtl/sobel_edge_magnitude.sv =====
// Top level of the Sobel edge magnitude block: config registers, front,
// job queue and back. Depends on sem_pkg, sem_front, sem_queue, sem_back.
//
// Pixels stream in raster order; each result gives row, column and the
// rounded, saturated Sobel magnitude. The front accepts a pixel with a line
// store read, then shifts the window, then emits each result it causes, or
// passes once through its emit state when it causes none. In the back a
// result goes through take, square, 19 root steps at two bits per cycle
// and output load; receiver stalls hold it at the output load.
// The queue lets the front run ahead by four results.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sem_pkg::PIX_W-1:0]      pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sem_pkg::COORD_W-1:0]    out_row,
    output logic [sem_pkg::COORD_W-1:0]    out_col,
    output logic [sem_pkg::PIX_W-1:0]      magnitude,
    output logic                           run_last,
    output logic                           frame_end
);
    import sem_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [PIX_W-1:0]  maxval_reg;
    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    job_t              fq_job, qb_job;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(512);
            height_reg <= SIZE_W'(512);
            maxval_reg <= PIX_W'(255);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_MAXVAL: maxval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .width_cfg(width_reg), .height_cfg(height_reg), .maxval_cfg(maxval_reg),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    sem_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
    );

    sem_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .maxval_cfg(maxval_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_row(out_row), .out_col(out_col), .magnitude(magnitude),
        .run_last(run_last), .frame_end(frame_end)
    );

`ifndef SYNTHESIS
    a_maxval_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_index == REG_MAXVAL) |=> $stable(maxval_reg))
        else $error("max value changed without write");
    a_width_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_index == REG_WIDTH) |=> $stable(width_reg))
        else $error("width changed without write");
    a_height_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_index == REG_HEIGHT) |=> $stable(height_reg))
        else $error("height changed without write");
`endif

endmodule

// ===== rtl/sem_queue.sv =====
// Small FIFO of window jobs between the front and back parts.
// Depends on sem_pkg for job_t.
module sem_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  sem_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output sem_pkg::job_t rd_data
);
    import sem_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != DEPTH[PTR_W:0]);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and count update.
    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage is written only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH[PTR_W:0])
        else $error("queue count above depth");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("push did not raise count");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not lower count");
`endif

endmodule

// ===== rtl/sem_front.sv =====
// Front part: accepts pixels, keeps line stores and the 3x3 window, and
// emits up to four window jobs per pixel in schedule order. Uses sem_pkg.
module sem_front #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sem_pkg::PIX_W-1:0]   pixel,
    input  logic [sem_pkg::SIZE_W-1:0]  width_cfg,
    input  logic [sem_pkg::SIZE_W-1:0]  height_cfg,
    input  logic [sem_pkg::PIX_W-1:0]   maxval_cfg,
    output logic                        job_valid,
    input  logic                        job_ready,
    output sem_pkg::job_t               job
);
    import sem_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                        $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int EW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MAXH = EW'(MAX_HEIGHT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd_reg, mid_rd_reg;

    logic [1:0]       st_reg, st_next;
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] pix_reg;
    logic [EW-1:0]    col_reg, row_reg;
    logic [EW-1:0]    cur_c_reg, cur_r_reg;
    logic [3:0]       pend_reg;
    logic [EW-1:0]    w_eff, h_eff, c_eff, r_eff;
    logic             clast, rlast;
    logic [3:0]       pend_calc;
    logic [1:0]       sel;
    logic [PIX_W-1:0] pclamp;
    logic             accept, wstep;

    // Flat window index for a column and row tap.
    function automatic logic [3:0] tap_idx(input logic [1:0] c, input logic [1:0] r);
        return ({2'b00, c} * 4'd3) + {2'b00, r};
    endfunction

    // Effective sizes. A counter beyond a shrunk size keeps its value and
    // simply counts as the last index.
    always_comb
    begin
        w_eff = EW'(width_cfg);
        h_eff = EW'(height_cfg);
        if (w_eff == '0) w_eff = EW'(1);
        if (w_eff > MAXW) w_eff = MAXW;
        if (h_eff == '0) h_eff = EW'(1);
        if (h_eff > MAXH) h_eff = MAXH;
        c_eff = col_reg;
        r_eff = row_reg;
        clast = (cur_c_reg + 1'b1 >= w_eff);
        rlast = (cur_r_reg + 1'b1 >= h_eff);
        pclamp = (pixel > maxval_cfg) ? maxval_cfg : pixel;
    end

    assign in_ready = (st_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign wstep    = (st_reg == ST_READ);

    // Pending result mask: bit0 (r-1,c-1), bit1 (r,c-1), bit2 (r-1,c), bit3 (r,c).
    always_comb
    begin
        pend_calc[0] = (cur_c_reg != '0) && (cur_r_reg != '0);
        pend_calc[1] = (cur_c_reg != '0) && rlast;
        pend_calc[2] = clast && (cur_r_reg != '0);
        pend_calc[3] = clast && rlast;
    end

    // Lowest pending result is emitted next.
    always_comb
    begin
        priority if (pend_reg[0]) sel = 2'd0;
        else if (pend_reg[1])     sel = 2'd1;
        else if (pend_reg[2])     sel = 2'd2;
        else                      sel = 2'd3;
    end

    // Sequencer state.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (accept) st_next = ST_READ;
            ST_READ: st_next = ST_EMIT;
            ST_EMIT:
            begin
                if (pend_reg == '0)
                    st_next = ST_IDLE;
                else if (job_ready && ((pend_reg & (pend_reg - 1'b1)) == '0))
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (wstep)
            begin
                for (int i = 0; i < 6; i++) win_reg[i] <= win_reg[i+3];
                win_reg[6] <= top_rd_reg;
                win_reg[7] <= mid_rd_reg;
                win_reg[8] <= pix_reg;
                pend_reg   <= pend_calc;
                if (clast)
                begin
                    col_reg <= '0;
                    row_reg <= rlast ? '0 : cur_r_reg + 1'b1;
                end
                else
                begin
                    col_reg <= cur_c_reg + 1'b1;
                    row_reg <= cur_r_reg;
                end
            end
            else if (st_reg == ST_EMIT && job_ready && pend_reg != '0)
            begin
                pend_reg <= pend_reg & (pend_reg - 1'b1);
            end
        end
    end

    // Line stores: read on accept, write back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= older_mem[c_eff[AW-1:0]];
            mid_rd_reg <= newer_mem[c_eff[AW-1:0]];
            pix_reg    <= pclamp;
            cur_c_reg  <= c_eff;
            cur_r_reg  <= r_eff;
        end
        if (wstep)
        begin
            older_mem[cur_c_reg[AW-1:0]] <= mid_rd_reg;
            newer_mem[cur_c_reg[AW-1:0]] <= pix_reg;
        end
    end

    // Window taps with border replication for the selected result.
    always_comb
    begin
        logic [1:0] cs0, cs1, cs2, rs0, rs1, rs2;
        logic       first_c, first_r;
        first_c = (cur_c_reg == EW'(1));
        first_r = (cur_r_reg == EW'(1));
        if (sel[1] == 1'b0)
        begin
            cs0 = first_c ? 2'd1 : 2'd0; cs1 = 2'd1; cs2 = 2'd2;
        end
        else
        begin
            cs0 = (cur_c_reg == '0) ? 2'd2 : 2'd1; cs1 = 2'd2; cs2 = 2'd2;
        end
        if (sel[0] == 1'b0)
        begin
            rs0 = first_r ? 2'd1 : 2'd0; rs1 = 2'd1; rs2 = 2'd2;
        end
        else
        begin
            rs0 = (cur_r_reg == '0) ? 2'd2 : 2'd1; rs1 = 2'd2; rs2 = 2'd2;
        end
        job.w0 = win_reg[tap_idx(cs0, rs0)]; job.w1 = win_reg[tap_idx(cs0, rs1)];
        job.w2 = win_reg[tap_idx(cs0, rs2)]; job.w3 = win_reg[tap_idx(cs1, rs0)];
        job.w4 = win_reg[tap_idx(cs1, rs1)]; job.w5 = win_reg[tap_idx(cs1, rs2)];
        job.w6 = win_reg[tap_idx(cs2, rs0)]; job.w7 = win_reg[tap_idx(cs2, rs1)];
        job.w8 = win_reg[tap_idx(cs2, rs2)];
        job.row = COORD_W'(sel[0] ? cur_r_reg : cur_r_reg - 1'b1);
        job.col = COORD_W'(sel[1] ? cur_c_reg : cur_c_reg - 1'b1);
        job.last = ((pend_reg & (pend_reg - 1'b1)) == '0);
        job.fend = (sel == 2'd3);
    end

    assign job_valid = (st_reg == ST_EMIT) && (pend_reg != '0);

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !in_ready)
        else $error("pixel taken while busy");
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wstep |=> (col_reg < w_eff) || $changed(width_cfg))
        else $error("column counter out of range");
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job.fend) |-> job.last)
        else $error("frame end not on last result");
`endif

endmodule

// ===== rtl/sem_back.sv =====
// Back part: Sobel sums, squared magnitude, iterative square root with
// rounding and saturation, and an output register. Uses sem_pkg.
module sem_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  sem_pkg::job_t                job,
    input  logic [sem_pkg::PIX_W-1:0]    maxval_cfg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sem_pkg::COORD_W-1:0]  out_row,
    output logic [sem_pkg::COORD_W-1:0]  out_col,
    output logic [sem_pkg::PIX_W-1:0]    magnitude,
    output logic                         run_last,
    output logic                         frame_end
);
    import sem_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              st_reg, st_next;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg, gx, gy;
    logic [SQ_W-1:0]         s_reg, res_reg, bit_reg;
    logic [SQ_CNT_W-1:0]     it_reg;
    logic [COORD_W-1:0]      row_reg, col_reg;
    logic                    last_reg, fend_reg;
    logic [SQ_W-1:0]         trial;
    logic [SQ_W-1:0]         q_round;
    logic                    take;
    logic                    ov_reg;
    logic [COORD_W-1:0]      orow_reg, ocol_reg;
    logic [PIX_W-1:0]        omag_reg;
    logic                    olast_reg, ofend_reg;

    // Gradient sums; w0..w2 left column top..bottom.
    always_comb
    begin
        gx = GRAD_W'(job.w6) + (GRAD_W'(job.w7) <<< 1) + GRAD_W'(job.w8)
           - GRAD_W'(job.w0) - (GRAD_W'(job.w1) <<< 1) - GRAD_W'(job.w2);
        gy = GRAD_W'(job.w2) + (GRAD_W'(job.w5) <<< 1) + GRAD_W'(job.w8)
           - GRAD_W'(job.w0) - (GRAD_W'(job.w3) <<< 1) - GRAD_W'(job.w6);
    end

    assign job_ready = (st_reg == ST_IDLE);
    assign take      = job_valid && job_ready;
    assign trial     = res_reg + bit_reg;
    // The remainder left in s_reg is s - q*q, so s > q*q + q means remainder > q.
    assign q_round   = (s_reg > res_reg) ? res_reg + 1'b1 : res_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (take) st_next = ST_SQ;
            ST_SQ:   st_next = ST_ROOT;
            ST_ROOT: if (it_reg == '0) st_next = ST_DONE;
            ST_DONE: if (!ov_reg || out_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_DONE && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Datapath: square, then one root bit pair per cycle.
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    gx_reg   <= gx;
                    gy_reg   <= gy;
                    row_reg  <= job.row;
                    col_reg  <= job.col;
                    last_reg <= job.last;
                    fend_reg <= job.fend;
                end
            end
            ST_SQ:
            begin
                s_reg   <= SQ_W'(gx_reg * gx_reg) + SQ_W'(gy_reg * gy_reg);
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
                it_reg  <= SQ_CNT_W'(ROOT_W - 1);
            end
            ST_ROOT:
            begin
                if (s_reg >= trial)
                begin
                    s_reg   <= s_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                it_reg  <= it_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    orow_reg  <= row_reg;
                    ocol_reg  <= col_reg;
                    omag_reg  <= (q_round > SQ_W'(maxval_cfg)) ? maxval_cfg
                                                               : PIX_W'(q_round);
                    olast_reg <= last_reg;
                    ofend_reg <= fend_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_row   = orow_reg;
    assign out_col   = ocol_reg;
    assign magnitude = omag_reg;
    assign run_last  = olast_reg;
    assign frame_end = ofend_reg;

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !job_ready)
        else $error("job taken while busy");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (magnitude <= $past(maxval_cfg) || magnitude <= maxval_cfg))
        else $error("magnitude above limit");
    a_root_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROOT && it_reg == '0) |=> st_reg == ST_DONE)
        else $error("root did not finish");
`endif

endmodule
